>>> rtl/core/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and codes for the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

   // Stored value and search key
   typedef logic signed [31:0] data_type;

   // Operation codes carried by a request beat
   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_SEARCH = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   // Status codes carried by a response beat
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOTFOUND  = 3'd4
   } status_type;

   // Response field widths
   localparam int PosWidth   = 7;
   localparam int CountWidth = 7;

   // Per-cycle commands broadcast to every cell of the chain
   typedef struct packed {
      logic push;   // shift values one place away from the top
      logic pop;    // shift values one place towards the top
      logic load;   // capture key match into the hit bit
      logic scan;   // shift hit bits one place towards the top
   } cell_ctrl_type;

endpackage

>>> rtl/core/lss_req_if.sv
// ----------------------------------------------------------------------------
// lss_req_if
// Request channel: operation and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lss_req_if;
   logic                 valid;
   logic                 ready;
   lss_pkg::opcode_type  opcode;
   lss_pkg::data_type    value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

>>> rtl/core/lss_rsp_if.sv
// ----------------------------------------------------------------------------
// lss_rsp_if
// Response channel: status, position, count, empty flag and top value.
// ----------------------------------------------------------------------------
interface lss_rsp_if;
   logic                               valid;
   logic                               ready;
   lss_pkg::status_type                status;
   logic [lss_pkg::PosWidth-1:0]       position;
   logic [lss_pkg::CountWidth-1:0]     count;
   logic                               empty_res;
   lss_pkg::data_type                  top_value;

   modport source (output valid, output status, output position, output count,
                   output empty_res, output top_value, input ready);
   modport sink   (input valid, input status, input position, input count,
                   input empty_res, input top_value, output ready);
endinterface

>>> rtl/core/lifo_stack_with_search.sv
// Push, pop and clear: response registered in the cycle after the request beat;
// one request per cycle while the response side keeps up.
// Search: every cell compares at once, then the hit bits shift to the top one
// cell a cycle; a match responds when its hit bit reaches cell 0, a miss once
// the bottom entry is scanned (no scan on an empty stack). No new request meanwhile.
// Reset empties the stack; stored values are not cleared.
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of signed 32-bit values built as a chain of shift cells,
// with push, pop, clear and search for the match nearest the top.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
   parameter int DEPTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   lss_req_if.sink  req,
   lss_rsp_if.source rsp
);
   import lss_pkg::*;

   localparam int FillWidth = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type               state_ff,    state_in;
   logic [FillWidth-1:0]    fill_ff,     fill_in;
   logic [FillWidth-1:0]    scan_pos_ff, scan_pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff,   status_in;
   logic [PosWidth-1:0]     position_ff, position_in;
   logic [CountWidth-1:0]   count_ff,    count_in;
   logic                    empty_ff,    empty_in;
   data_type                top_ff,      top_in;

   cell_ctrl_type           cell_ctrl;
   data_type                cell_value [DEPTH];
   logic                    cell_hit   [DEPTH];
   logic                    rsp_free;
   logic                    is_empty;
   logic                    is_full;
   logic [FillWidth-1:0]    scan_next;

   // Chain of cells, top of stack at cell 0
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      data_type up_value;
      data_type down_value;
      logic     down_hit;

      if (g == 0) begin : g_top
         assign up_value = req.value;
      end else begin : g_mid
         assign up_value = cell_value[g-1];
      end

      if (g == DEPTH - 1) begin : g_bottom
         assign down_value = '0;
         assign down_hit   = 1'b0;
      end else begin : g_inner
         assign down_value = cell_value[g+1];
         assign down_hit   = cell_hit[g+1];
      end

      lss_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .key        (req.value),
         .up_value   (up_value),
         .down_value (down_value),
         .down_hit   (down_hit),
         .value      (cell_value[g]),
         .hit        (cell_hit[g])
      );
   end

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign is_empty  = (fill_ff == '0);
   assign is_full   = (fill_ff == FillWidth'(DEPTH));
   assign scan_next = scan_pos_ff + FillWidth'(1);

   // Next-state and response logic
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      scan_pos_in  = scan_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      position_in  = position_ff;
      count_in     = count_ff;
      empty_in     = empty_ff;
      top_in       = top_ff;
      cell_ctrl    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && rsp_free) begin
               rsp_valid_in = 1'b1;
               position_in  = '0;
               status_in    = ST_OK;
               top_in       = '0;
               unique case (req.opcode)
                  OP_PUSH: begin
                     if (is_full) begin
                        status_in = ST_OVERFLOW;
                        top_in    = cell_value[0];
                     end else begin
                        cell_ctrl.push = 1'b1;
                        fill_in        = fill_ff + FillWidth'(1);
                        top_in         = req.value;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        status_in = ST_UNDERFLOW;
                     end else begin
                        cell_ctrl.pop = 1'b1;
                        fill_in       = fill_ff - FillWidth'(1);
                        if (fill_ff != FillWidth'(1)) begin
                           top_in = cell_value[1];
                        end
                     end
                  end
                  OP_SEARCH: begin
                     if (is_empty) begin
                        status_in = ST_NOTFOUND;
                     end else begin
                        // hold the response until the scan ends
                        rsp_valid_in   = 1'b0;
                        cell_ctrl.load = 1'b1;
                        scan_pos_in    = '0;
                        state_in       = S_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                     fill_in = fill_ff;
                  end
               endcase
               count_in = CountWidth'(fill_in);
               empty_in = (fill_in == '0);
            end
         end

         S_SCAN: begin
            // cell 0's hit bit stands for the entry at scan_pos from the top
            if (rsp_free) begin
               if (cell_hit[0] || (scan_next == fill_ff)) begin
                  rsp_valid_in = 1'b1;
                  status_in    = cell_hit[0] ? ST_FOUND : ST_NOTFOUND;
                  position_in  = cell_hit[0] ? PosWidth'(scan_next) : '0;
                  count_in     = CountWidth'(fill_ff);
                  empty_in     = 1'b0;
                  top_in       = cell_value[0];
                  state_in     = S_IDLE;
               end else begin
                  cell_ctrl.scan = 1'b1;
                  scan_pos_in    = scan_next;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_pos_ff <= scan_pos_in;
      status_ff   <= status_in;
      position_ff <= position_in;
      count_ff    <= count_in;
      empty_ff    <= empty_in;
      top_ff      <= top_in;
   end

   assign req.ready     = (state_ff == S_IDLE) && rsp_free;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.position  = position_ff;
   assign rsp.count     = count_ff;
   assign rsp.empty_res = empty_ff;
   assign rsp.top_value = top_ff;

endmodule

>>> rtl/core/lss_cell.sv
// ----------------------------------------------------------------------------
// lss_cell
// One stack entry: holds a value and a search hit bit, shifts with its
// neighbours on push, pop and search scan.
// ----------------------------------------------------------------------------
module lss_cell (
   input  logic                   clock,
   input  lss_pkg::cell_ctrl_type ctrl,
   input  lss_pkg::data_type      key,
   input  lss_pkg::data_type      up_value,    // neighbour nearer the top
   input  lss_pkg::data_type      down_value,  // neighbour nearer the bottom
   input  logic                   down_hit,
   output lss_pkg::data_type      value,
   output logic                   hit
);
   import lss_pkg::*;

   data_type value_ff;
   logic     hit_ff;

   // Value storage: shift down on push, up on pop
   always_ff @(posedge clock) begin
      priority if (ctrl.push) begin
         value_ff <= up_value;
      end else if (ctrl.pop) begin
         value_ff <= down_value;
      end else begin
         value_ff <= value_ff;
      end
   end

   // Hit bit: local compare on load, then shifted towards the top
   always_ff @(posedge clock) begin
      priority if (ctrl.load) begin
         hit_ff <= (value_ff == key);
      end else if (ctrl.scan) begin
         hit_ff <= down_hit;
      end else begin
         hit_ff <= hit_ff;
      end
   end

   assign value = value_ff;
   assign hit   = hit_ff;

endmodule
